/* rtl/swsr_pkg.sv */
// ----------------------------------------------------------------------------
// swsr_pkg: shared definitions for the stop-and-wait sequencing block
// Widths, request and status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package swsr_pkg;

	// Width of the internal sequence arithmetic. Packet fields stay 32 bits.
	localparam int SEQ_WIDTH = 32;

	localparam int RX_WIDTH    = 32;
	localparam int TICK_WIDTH  = 32;
	localparam int RETRY_WIDTH = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;

	typedef enum logic [1:0] {
		REQ_RX_PACKET = 2'd0,
		REQ_COMMIT    = 2'd1,
		REQ_TICK      = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_WAIT       = 2'd1,
		ST_RETRANSMIT = 2'd2
	} status_t;

	localparam logic [CFG_IDX_W-1:0] REG_ROLE_SERVER   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = CFG_IDX_W'(1);

	localparam logic [TICK_WIDTH-1:0] TIMEOUT_RESET = TICK_WIDTH'(1000);

endpackage

/* rtl/stop_and_wait_seq_retransmit_top.sv */
// ----------------------------------------------------------------------------
// stop_and_wait_seq_retransmit_top: stop-and-wait ARQ sequencing and retransmit
// Tracks the sequence number of one link end, and decides send, resend and done.
// ----------------------------------------------------------------------------
//
// Usage:
//   Input channel (in_valid / in_stall) carries one request per transaction:
//   a received packet header (req_type 0, rx_seq), a commit or poll (1), or a
//   timer tick (2). Every request yields exactly one result transaction on the
//   output channel (out_valid / out_stall) with status, transmit, seq_out,
//   retry_count and ack_pending.
//   A request is first held in the input register, and the edge that moves
//   it on writes both the state registers and the result register.
//   One request per cycle is sustained while the output is not stalled,
//   because state is updated at the same edge the result is captured, so
//   the following request already sees it.
//   When the receiver stalls, the result register holds; the input register
//   still takes one more request, then in_stall rises until the result drains.
//   The configuration port (cfg_valid / cfg_ready / cfg_index / cfg_data) is
//   always ready; writing role_server also reloads the sequence counter
//   (0 for server, all ones for client). Unknown indexes are ignored.
//   Reset puts the block in the client role, timeout 1000 ticks, counter all
//   ones, no ack pending and both channels empty.
//
module stop_and_wait_seq_retransmit_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           req_type,
	input  logic signed [swsr_pkg::RX_WIDTH-1:0] rx_seq,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [1:0]                           status,
	output logic                                 transmit,
	output logic signed [31:0]                   seq_out,
	output logic [swsr_pkg::RETRY_WIDTH-1:0]     retry_count,
	output logic                                 ack_pending,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [swsr_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [swsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import swsr_pkg::*;

	// Configuration registers.
	logic                  role_server_q;
	logic [TICK_WIDTH-1:0] timeout_q;

	// Protocol state.
	logic [SEQ_WIDTH-1:0]   seq_q;
	logic [SEQ_WIDTH-1:0]   sent_seq_q;
	logic                   waiting_q;
	logic [TICK_WIDTH-1:0]  elapsed_q;
	logic [RETRY_WIDTH-1:0] retries_q;

	// Input stage.
	logic                       valid_s1;
	logic [1:0]                 req_s1;
	logic signed [RX_WIDTH-1:0] rx_s1;

	// Result stage.
	logic                   valid_s2;
	logic [1:0]             status_s2;
	logic                   transmit_s2;
	logic signed [31:0]     seq_out_s2;
	logic [RETRY_WIDTH-1:0] retries_s2;
	logic                   waiting_s2;

	// Next-state values.
	logic [SEQ_WIDTH-1:0]   seq_d;
	logic [SEQ_WIDTH-1:0]   sent_seq_d;
	logic                   waiting_d;
	logic [TICK_WIDTH-1:0]  elapsed_d;
	logic [RETRY_WIDTH-1:0] retries_d;
	logic [1:0]             status_d;
	logic                   transmit_d;

	logic                 advance;
	logic                 load_s1;
	logic signed [63:0]   rx_wide;
	logic [SEQ_WIDTH-1:0] rx_seq_w;
	logic signed [63:0]   seq_wide;

	// The result register frees up when it is empty or being taken.
	assign advance   = !valid_s2 || !out_stall;
	assign load_s1   = !valid_s1 || advance;
	assign in_stall  = !load_s1;
	assign cfg_ready = 1'b1;

	// Received numbers are sign-extended (or cut) to the sequence width.
	assign rx_wide  = 64'(rx_s1);
	assign rx_seq_w = rx_wide[SEQ_WIDTH-1:0];

	always_comb begin
		seq_d      = seq_q;
		sent_seq_d = sent_seq_q;
		waiting_d  = waiting_q;
		elapsed_d  = elapsed_q;
		retries_d  = retries_q;
		status_d   = ST_WAIT;
		transmit_d = 1'b0;
		case (req_s1)
			REQ_RX_PACKET: begin
				if (role_server_q) begin
					// Server accepts only the expected number, then moves on.
					if (rx_seq_w == seq_q) begin
						seq_d    = seq_q + SEQ_WIDTH'(1);
						status_d = ST_OK;
					end
				end else if ($signed(rx_seq_w) > $signed(seq_q)) begin
					// Client adopts any newer number.
					seq_d    = rx_seq_w;
					status_d = ST_OK;
				end
			end
			REQ_COMMIT: begin
				if (!waiting_q) begin
					transmit_d = 1'b1;
					sent_seq_d = seq_q;
					elapsed_d  = '0;
					retries_d  = '0;
					waiting_d  = 1'b1;
				end else if (sent_seq_q != seq_q) begin
					// The sequence number moved on, so the peer acknowledged.
					waiting_d = 1'b0;
					status_d  = ST_OK;
				end else if (elapsed_q >= timeout_q) begin
					transmit_d = 1'b1;
					status_d   = ST_RETRANSMIT;
					elapsed_d  = '0;
					if (retries_q != '1) begin
						retries_d = retries_q + RETRY_WIDTH'(1);
					end
				end
			end
			REQ_TICK: begin
				if (elapsed_q != '1) begin
					elapsed_d = elapsed_q + TICK_WIDTH'(1);
				end
				status_d = ST_OK;
			end
			default: begin
				status_d = ST_WAIT;
			end
		endcase
	end

	assign seq_wide = 64'($signed(seq_d));

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1 && in_valid) begin
			req_s1 <= req_type;
			rx_s1  <= rx_seq;
		end
	end

	// State and configuration. A role write reloads the counter; writes must only
	// arrive while no request is in flight; the block does not enforce it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			role_server_q <= 1'b0;
			timeout_q     <= TIMEOUT_RESET;
			seq_q         <= '1;
			sent_seq_q    <= '0;
			waiting_q     <= 1'b0;
			elapsed_q     <= '0;
			retries_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ROLE_SERVER) begin
				role_server_q <= cfg_data[0];
				seq_q         <= cfg_data[0] ? '0 : '1;
			end else if (cfg_index == REG_TIMEOUT_TICKS) begin
				timeout_q <= cfg_data[TICK_WIDTH-1:0];
			end
		end else if (valid_s1 && advance) begin
			seq_q      <= seq_d;
			sent_seq_q <= sent_seq_d;
			waiting_q  <= waiting_d;
			elapsed_q  <= elapsed_d;
			retries_q  <= retries_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status_s2   <= status_d;
			transmit_s2 <= transmit_d;
			seq_out_s2  <= seq_wide[31:0];
			retries_s2  <= retries_d;
			waiting_s2  <= waiting_d;
		end
	end

	assign out_valid   = valid_s2;
	assign status      = status_s2;
	assign transmit    = transmit_s2;
	assign seq_out     = seq_out_s2;
	assign retry_count = retries_s2;
	assign ack_pending = waiting_s2;

endmodule
